// ----- hw/rtl/xrr_pkg.sv -----
// Shared constants and control types for the xorshift range generator.
package xrr_pkg;

    typedef logic [31:0] t_word;

    localparam t_word MULT_CONST = 32'hDEADBF03;
    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 21;
    localparam int unsigned SHIFT_C = 11;

    localparam logic OP_RANGE = 1'b0;
    localparam logic OP_BIT   = 1'b1;

    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;      // request beat taken, advance state
        logic cfg_load;  // seed beat taken
        logic mul;       // scramble multiply, clear remainder
        logic div_step;  // one restoring division step
        logic out_load;  // capture result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic bit_req;
        logic full_span;
    } t_dp_sts;

endpackage

// ----- hw/rtl/xrr_req_if.sv -----
// Request channel: opcode and range bounds.
interface xrr_req_if import xrr_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  opcode;
    t_word low_bound;
    t_word high_bound;

    modport source (output valid, output opcode, output low_bound, output high_bound,
                    input ready);
    modport sink   (input valid, input opcode, input low_bound, input high_bound,
                    output ready);
endinterface

// ----- hw/rtl/xrr_rsp_if.sv -----
// Response channel: one result value per request.
interface xrr_rsp_if import xrr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- hw/rtl/xrr_cfg_if.sv -----
// Seed write channel.
interface xrr_cfg_if import xrr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

// ----- hw/rtl/xorshift_range_random.sv -----
// Range request: from request beat to result valid, a multiply, 32 modulo steps and the output load.
// Bit request or full span (high - low = all ones): the modulo steps are skipped.
// One request at a time: the next is taken after the output load, which waits while a result is untaken.
// The bit-serial modulo unit works one remainder bit per cycle.
// Synchronous active-low reset: generator state becomes 1, no result pending.
module xorshift_range_random import xrr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    xrr_req_if.sink      i_req,
    xrr_rsp_if.source    o_rsp,
    xrr_cfg_if.sink      i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    xrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    xrr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_opcode     (i_req.opcode),
        .i_low_bound  (i_req.low_bound),
        .i_high_bound (i_req.high_bound),
        .i_seed       (i_cfg.seed),
        .o_value      (o_rsp.value)
    );

endmodule

// ----- hw/rtl/xrr_datapath.sv -----
// Datapath: xorshift state, scramble multiply, bit-serial modulo, output register.
module xrr_datapath import xrr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    input  logic    i_opcode,
    input  t_word   i_low_bound,
    input  t_word   i_high_bound,
    input  t_word   i_seed,
    output t_word   o_value
);

    t_word r_state;
    t_word r_x;
    t_word r_lo;
    t_word r_div;
    logic  r_opcode;
    t_word r_prod;
    t_word r_rem;
    t_word r_out;

    t_word       sh_a;
    t_word       sh_b;
    t_word       n_state;
    t_word       n_prod;
    logic [32:0] trial;
    logic [32:0] trial_diff;
    t_word       n_rem;
    t_word       result;

    // xorshift advance
    always_comb begin
        sh_a    = r_state ^ (r_state >> SHIFT_A);
        sh_b    = sh_a ^ (sh_a << SHIFT_B);
        n_state = sh_b ^ (sh_b >> SHIFT_C);
    end

    assign n_prod = r_x * MULT_CONST;

    // restoring step: shift next dividend bit into remainder, subtract if it fits
    always_comb begin
        trial      = {r_rem, r_prod[31]};
        trial_diff = trial - {1'b0, r_div};
        n_rem      = trial_diff[32] ? trial[31:0] : trial_diff[31:0];
    end

    always_comb begin
        if (r_opcode == OP_BIT) begin
            result = {31'b0, r_x[0]};
        end else if (r_div == '0) begin
            result = r_prod + r_lo;
        end else begin
            result = r_rem + r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= 32'd1;
        end else if (i_cmd.cfg_load) begin
            r_state <= (i_seed == '0) ? 32'd1 : i_seed;
        end else if (i_cmd.load) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x      <= n_state;
            r_lo     <= i_low_bound;
            r_div    <= i_high_bound - i_low_bound + 32'd1;  // zero means full span
            r_opcode <= i_opcode;
        end
        if (i_cmd.mul) begin
            r_prod <= n_prod;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_prod <= {r_prod[30:0], 1'b0};
            r_rem  <= n_rem;
        end
        if (i_cmd.out_load) begin
            r_out <= result;
        end
    end

    assign o_sts.bit_req   = (r_opcode == OP_BIT);
    assign o_sts.full_span = (r_div == '0);
    assign o_value         = r_out;

endmodule

// ----- hw/rtl/xrr_ctrl.sv -----
// Controller: sequences accept, multiply, division steps and result hand-off.
module xrr_ctrl import xrr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       r_st;
    logic [1:0]       n_st;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    // a pending seed beat goes first
    assign o_req_ready = (r_st == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_st == ST_IDLE);
    assign out_free    = !r_out_valid || i_rsp_ready;

    always_comb begin
        n_st           = r_st;
        n_cnt          = r_cnt;
        o_cmd          = '0;
        o_cmd.load     = i_req_valid && o_req_ready;
        o_cmd.cfg_load = i_cfg_valid && o_cfg_ready;
        unique case (r_st)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_st = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_st      = (i_sts.bit_req || i_sts.full_span) ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_st = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_st           = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp_valid = r_out_valid;

    a_accept_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_st == ST_MUL))
        else $error("request beat did not start the multiply");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIV && r_cnt == CNT_W'(DIV_STEPS - 1)) |=> (r_st == ST_DONE))
        else $error("division did not finish after last step");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DONE && r_out_valid && !i_rsp_ready) |=> (r_st == ST_DONE))
        else $error("result overwrote an untaken output beat");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("output register loaded without valid");

    a_cfg_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cfg_load |-> (r_st == ST_IDLE && !o_cmd.mul && !o_cmd.div_step))
        else $error("seed write during a request");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the xorshift range generator: predicted values versus response beats.
module testbench;
    import xrr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;

    // Scoreboard: tracks the generator state and the queue of values still owed by the block.
    class xrr_scoreboard;
        t_word       gen_state;
        t_word       value_q[$];
        int unsigned errors;

        function new();
            gen_state = 32'd1;
            errors    = 0;
        endfunction

        function void load_seed(t_word seed);
            gen_state = (seed == '0) ? 32'd1 : seed;
        endfunction

        function t_word advance_state();
            t_word x;
            x = gen_state;
            x ^= x >> SHIFT_A;
            x ^= x << SHIFT_B;
            x ^= x >> SHIFT_C;
            gen_state = x;
            return x;
        endfunction

        function void note_request(logic opcode, t_word low_bound, t_word high_bound);
            t_word x;
            t_word span;
            t_word scrambled;
            x = advance_state();
            if (opcode == OP_BIT) begin
                value_q.push_back({31'd0, x[0]});
            end else begin
                span      = high_bound - low_bound;
                scrambled = x * MULT_CONST;
                // full span: span + 1 wraps to zero, product is used whole
                if (span != '1) scrambled = scrambled % (span + 32'd1);
                value_q.push_back(scrambled + low_bound);
            end
        endfunction

        function int pending();
            return value_q.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_value(t_word got);
            t_word want;
            if (value_q.size() == 0) begin
                report($sformatf("unexpected response value %08h", got));
            end else begin
                want = value_q.pop_front();
                if (got !== want)
                    report($sformatf("value %08h, expected %08h", got, want));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    xrr_req_if req_if ();
    xrr_rsp_if rsp_if ();
    xrr_cfg_if cfg_if ();

    xorshift_range_random uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    xrr_scoreboard sb = new();

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_len  = 0;
    int quiet_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Beat monitor and watchdog; values read here are the ones settled before the edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready) sb.load_seed(cfg_if.seed);
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.opcode, req_if.low_bound, req_if.high_bound);
            if (rsp_if.valid && rsp_if.ready) sb.check_value(rsp_if.value);
            if ((cfg_if.valid && cfg_if.ready) || (req_if.valid && req_if.ready) ||
                (rsp_if.valid && rsp_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    // Response side: random stalls, plus a long hold-off counted here.
    initial begin
        int hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_len > 0) begin
                hold_left = hold_len;
                hold_len <= 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task send_request(logic opcode, t_word low_bound, t_word high_bound);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.opcode     <= opcode;
        req_if.low_bound  <= low_bound;
        req_if.high_bound <= high_bound;
        do @(posedge clk); while (!req_if.ready);
    endtask

    task send_random_request();
        t_word lo;
        t_word hi;
        lo = $urandom;
        hi = $urandom;
        if ($urandom_range(3) == 0) begin
            send_request(OP_BIT, lo, hi);
        end else begin
            case ($urandom_range(9))
                0, 1, 2, 3: ;
                4, 5, 6:    hi = lo + $urandom_range(255);
                7:          hi = lo - 32'd1;
                8:          hi = lo;
                default:    hi = lo + ((32'd1 << $urandom_range(31)) - 32'd1);
            endcase
            send_request(OP_RANGE, lo, hi);
        end
    endtask

    // one edge first so the monitor has noted the last request beat
    task wait_idle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
    endtask

    task write_seed(t_word seed);
        cfg_if.valid <= 1'b1;
        cfg_if.seed  <= seed;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task run_directed();
        send_request(OP_RANGE, 32'h0000_0000, 32'hFFFF_FFFF);   // full span
        send_request(OP_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);   // full span, signed view
        send_request(OP_RANGE, 32'h0000_0005, 32'h0000_0004);   // full span, low nonzero
        send_request(OP_RANGE, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_RANGE, 32'h1234_5678, 32'h1234_5678);
        send_request(OP_RANGE, 32'h0000_0000, 32'h0000_0001);
        send_request(OP_RANGE, 32'h0000_0000, 32'h0000_0009);
        send_request(OP_RANGE, 32'hFFFF_FFF6, 32'h0000_000A);   // -10..10
        send_request(OP_RANGE, 32'h0000_0000, 32'hFFFF_FFFE);
        send_request(OP_RANGE, 32'h0000_0000, 32'h7FFF_FFFF);
        send_request(OP_RANGE, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(OP_RANGE, 32'h0000_0064, 32'h0000_000A);   // reversed bounds
        send_request(OP_RANGE, 32'hFFFF_FFFF, 32'h0000_0000);   // reversed, span 1
        send_request(OP_RANGE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(OP_BIT,   32'h0000_0000, 32'h0000_0000);
        send_request(OP_BIT,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_BIT,   32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_request(OP_BIT,   32'h0000_0010, 32'h0000_0001);
        send_request(OP_RANGE, 32'hFFFF_FF00, 32'hFFFF_FFFF);
        send_request(OP_RANGE, 32'h0000_0001, 32'hFFFF_FFFF);
    endtask

    task run_phase(t_word seed, int idle, int stall, int hold, int items);
        wait_idle();
        write_seed(seed);
        idle_pct  = idle;
        stall_pct = stall;
        if (hold > 0) hold_len <= hold;
        repeat (items) send_random_request();
    endtask

    initial begin
        rst_n             <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.opcode     <= OP_RANGE;
        req_if.low_bound  <= '0;
        req_if.high_bound <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.seed       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_phase(32'h0000_0000, 0, 0, 0, 230);        // zero seed becomes one
        run_phase(32'hFFFF_FFFF, 52, 0, 0, 230);
        run_phase($urandom, 0, 52, 0, 230);
        run_phase(32'h8000_0000, 32, 32, 0, 230);
        run_phase($urandom, 0, 0, 400, 210);           // long response hold-off
        run_phase(32'h0000_0001, 0, 0, 0, 20);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
